FILE: rtl/ssl_pkg.sv
// ----------------------------------------------------------------------------
// ssl_pkg
// Shared types and constants of the Stanley steering law core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssl_pkg;

   // Queue between the front and the back part.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Integer square root of a 48-bit radicand: one result bit per stage.
   localparam int ROOT_BITS = 24;
   localparam int RAD_BITS  = 2 * ROOT_BITS;
   localparam int REM_BITS  = ROOT_BITS + 2;

   // CORDIC stage count, limited to the angle table length.
   localparam int ATAN_LEN       = 24;
   localparam int CORDIC_STAGES  = 16;
   localparam int CORDIC_USED    = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
   localparam int CORDIC_W       = 44;
   localparam int ANGLE_W        = 27;

   // Pipeline positions of the back part.
   localparam int POS_SQ     = 0;
   localparam int POS_SUM    = 1;
   localparam int POS_ROOT   = 2;
   localparam int POS_MUL    = POS_ROOT + ROOT_BITS;
   localparam int POS_CORDIC = POS_MUL + 1;
   localparam int POS_ADD    = POS_CORDIC + CORDIC_USED;
   localparam int POS_OUT    = POS_ADD + 1;
   localparam int PIPE_LEN   = POS_OUT + 1;

   // Q2.13 angle constants.
   localparam logic signed [17:0] Q_PI         = 18'sd25736;
   localparam logic signed [17:0] Q_TWO_PI     = 18'sd51472;
   localparam logic signed [17:0] Q_QUARTER_PI = 18'sd6434;

   // Register indexes of the configuration port.
   localparam logic CSR_GAIN  = 1'b0;
   localparam logic CSR_SPEED = 1'b1;

   // atan(2^-i) in units of 2^-24 rad.
   localparam logic [24:0] ATAN_TABLE [ATAN_LEN] = '{
      25'd13176795, 25'd7778716, 25'd4110060, 25'd2086331, 25'd1047214, 25'd524117,
      25'd262123, 25'd131069, 25'd65536, 25'd32768, 25'd16384, 25'd8192,
      25'd4096, 25'd2048, 25'd1024, 25'd512, 25'd256, 25'd128,
      25'd64, 25'd32, 25'd16, 25'd8, 25'd4, 25'd2
   };

   // One accepted pose.
   typedef struct packed {
      logic signed [23:0] rel_x;
      logic signed [23:0] rel_y;
      logic signed [15:0] rel_heading;
      logic               forward;
   } pose_type;

   // What travels beside the arithmetic through the back part.
   typedef struct packed {
      logic signed [15:0] rel_heading;
      logic               forward;
      logic               y_positive;
      logic               dist_zero;
   } meta_type;

   // Queue read side, seen by the back part.
   typedef struct packed {
      logic     valid;
      pose_type pose;
   } queue_out_type;

endpackage

`default_nettype wire

FILE: rtl/stanley_steering_law_core.sv
// ----------------------------------------------------------------------------
// stanley_steering_law_core
// Stanley lateral steering law: heading plus atan of gained cross-track error.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Content
//   req_     in         one pose: offsets, relative heading, direction bit
//   rsp_     out        one steering angle and signed speed command
//   csr_     in         register writes: cross-track gain, drive speed
//
// One item per cycle sustained while results are taken, through squares,
// sum, 24 square root stages, gain multiply, 16 CORDIC stages, heading add,
// wrap and clamp. Synchronous reset empties the queue and the pipeline and
// loads the register defaults. When a result waits with rsp_tready low the
// pipeline holds and the four-entry queue keeps taking items until full.
// ----------------------------------------------------------------------------
`default_nettype none

module stanley_steering_law_core import ssl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // rel_x, rel_y, rel_heading
   input  wire logic          req_tuser,   // forward
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata,   // steer_angle, speed_command, zero pad
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic          csr_index,
   input  wire logic [15:0]   csr_data
);

   logic [15:0]   gain_ff, speed_ff;
   queue_out_type queue_out;
   logic          queue_pop;

   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= 16'd1280;
         speed_ff <= 16'd1000;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:  gain_ff  <= csr_data;
            CSR_SPEED: speed_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   ssl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .queue_out  (queue_out),
      .queue_pop  (queue_pop)
   );

   ssl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_out  (queue_out),
      .queue_pop  (queue_pop),
      .gain       (gain_ff),
      .speed      (speed_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire

FILE: rtl/ssl_front.sv
// ----------------------------------------------------------------------------
// ssl_front
// Accepts pose items, unpacks them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_front import ssl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [63:0]   req_tdata,   // rel_x, rel_y, rel_heading
   input  wire logic          req_tuser,   // forward
   output queue_out_type      queue_out,
   input  wire logic          queue_pop
);

   pose_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  push;
   logic                  pop;
   pose_type              pose;

   // Unpack the item.
   always_comb begin
      pose.rel_x       = req_tdata[23:0];
      pose.rel_y       = req_tdata[47:24];
      pose.rel_heading = req_tdata[63:48];
      pose.forward     = req_tuser;
   end

   assign req_tready      = (count_ff != QUEUE_DEPTH[QUEUE_AW:0]);
   assign push            = req_tvalid && req_tready;
   assign pop             = queue_pop && (count_ff != '0);
   assign queue_out.valid = (count_ff != '0);
   assign queue_out.pose  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= pose;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/ssl_back.sv
// ----------------------------------------------------------------------------
// ssl_back
// Pipelined steering law: distance, square root, gain, CORDIC, wrap, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module ssl_back import ssl_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  queue_out_type      queue_out,
   output logic               queue_pop,
   input  wire logic [15:0]   gain,
   input  wire logic [15:0]   speed,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output logic [31:0]        rsp_tdata    // steer_angle, speed_command, pad
);

   logic                 vld_ff [PIPE_LEN];
   meta_type             meta_ff [PIPE_LEN];
   meta_type             meta_in;
   logic                 adv;

   // Whole pipeline moves when the output slot is free or being taken.
   assign adv       = !vld_ff[POS_OUT] || rsp_tready;
   assign queue_pop = adv;

   always_comb begin
      meta_in.rel_heading = queue_out.pose.rel_heading;
      meta_in.forward     = queue_out.pose.forward;
      meta_in.y_positive  = (queue_out.pose.rel_y > 24'sd0);
      meta_in.dist_zero   = 1'b0;
   end

   // Valid chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LEN; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= queue_out.valid;
         for (int i = 1; i < PIPE_LEN; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   // Squares of both offsets.
   logic signed [47:0] sqx, sqy;
   logic [46:0]        sqx_ff, sqy_ff;
   logic [RAD_BITS-1:0] rad0_ff;

   assign sqx = queue_out.pose.rel_x * queue_out.pose.rel_x;
   assign sqy = queue_out.pose.rel_y * queue_out.pose.rel_y;

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff  <= sqx[46:0];
         sqy_ff  <= sqy[46:0];
         rad0_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
      end
   end

   // Square root, one result bit per stage.
   logic [RAD_BITS-1:0]  rad_ff  [ROOT_BITS];
   logic [REM_BITS-1:0]  rem_ff  [ROOT_BITS];
   logic [ROOT_BITS-1:0] root_ff [ROOT_BITS];

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
      logic [RAD_BITS-1:0]  rad_prev;
      logic [REM_BITS-1:0]  rem_prev;
      logic [ROOT_BITS-1:0] root_prev;
      logic [REM_BITS+1:0]  trial_rem;
      logic [REM_BITS+1:0]  trial_sub;
      logic [RAD_BITS-1:0]  rad_in;
      logic [REM_BITS-1:0]  rem_in;
      logic [ROOT_BITS-1:0] root_in;

      if (k == 0) begin : g_first
         assign rad_prev  = rad0_ff;
         assign rem_prev  = '0;
         assign root_prev = '0;
      end else begin : g_next
         assign rad_prev  = rad_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign root_prev = root_ff[k-1];
      end

      always_comb begin
         trial_rem = {rem_prev, rad_prev[RAD_BITS-1 -: 2]};
         trial_sub = {2'b00, root_prev, 2'b01};
         rad_in    = {rad_prev[RAD_BITS-3:0], 2'b00};
         if (trial_rem >= trial_sub) begin
            rem_in  = REM_BITS'(trial_rem - trial_sub);
            root_in = {root_prev[ROOT_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial_rem[REM_BITS-1:0];
            root_in = {root_prev[ROOT_BITS-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            rad_ff[k]  <= rad_in;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   // Zero-distance flag joins the side data at the gain stage.
   meta_type meta_mul;

   always_comb begin
      meta_mul           = meta_ff[POS_MUL - 1];
      meta_mul.dist_zero = (root_ff[ROOT_BITS-1] == '0);
   end

   // Side data chain; the zero-distance flag is set at the gain stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= meta_in;
         for (int i = 1; i < PIPE_LEN; i++) begin
            if (i == POS_MUL) begin
               meta_ff[i] <= meta_mul;
            end else begin
               meta_ff[i] <= meta_ff[i-1];
            end
         end
      end
   end

   // Gain times distance.
   logic [39:0] num_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= gain * root_ff[ROOT_BITS-1];
      end
   end

   // Vectoring CORDIC on (speed + 1) * 256, gain * distance.
   logic signed [CORDIC_W-1:0] cx_ff [CORDIC_USED];
   logic signed [CORDIC_W-1:0] cy_ff [CORDIC_USED];
   logic signed [ANGLE_W-1:0]  cz_ff [CORDIC_USED];
   logic signed [CORDIC_W-1:0] den;

   assign den = CORDIC_W'({({1'b0, speed} + 17'd1), 8'h00});

   for (genvar j = 0; j < CORDIC_USED; j++) begin : g_cordic
      logic signed [CORDIC_W-1:0] x_prev, y_prev, x_in, y_in;
      logic signed [ANGLE_W-1:0]  z_prev, z_in, step;

      if (j == 0) begin : g_first
         assign x_prev = den;
         assign y_prev = CORDIC_W'(num_ff);
         assign z_prev = '0;
      end else begin : g_next
         assign x_prev = cx_ff[j-1];
         assign y_prev = cy_ff[j-1];
         assign z_prev = cz_ff[j-1];
      end

      assign step = ANGLE_W'(ATAN_TABLE[j]);

      always_comb begin
         if (y_prev > 0) begin
            x_in = x_prev + (y_prev >>> j);
            y_in = y_prev - (x_prev >>> j);
            z_in = z_prev + step;
         end else begin
            x_in = x_prev - (y_prev >>> j);
            y_in = y_prev + (x_prev >>> j);
            z_in = z_prev - step;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cx_ff[j] <= x_in;
            cy_ff[j] <= y_in;
            cz_ff[j] <= z_in;
         end
      end
   end

   // Round the angle, apply the error sign and add the heading.
   meta_type                  meta_add;
   logic signed [ANGLE_W-1:0] z_round;
   logic signed [17:0]        term, head_eff;
   logic signed [17:0]        sum_ff;

   assign meta_add = meta_ff[POS_ADD - 1];

   always_comb begin
      z_round = cz_ff[CORDIC_USED-1] + ANGLE_W'(1024);
      term    = 18'(z_round >>> 11);
      if (meta_add.dist_zero) begin
         term = '0;
      end else if (!meta_add.y_positive) begin
         term = -term;
      end
      head_eff = 18'(meta_add.rel_heading);
      if (!meta_add.forward) begin
         head_eff = -head_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= head_eff + term;
      end
   end

   // Wrap into [-pi, pi], clamp to +/-pi/4, form the speed command.
   logic signed [17:0] wrapped, clamped;
   logic signed [16:0] speed_cmd;
   logic signed [13:0] angle_ff;
   logic signed [16:0] speed_cmd_ff;

   always_comb begin
      wrapped = sum_ff;
      if (sum_ff > Q_PI) begin
         wrapped = sum_ff - Q_TWO_PI;
      end else if (sum_ff < -Q_PI) begin
         wrapped = sum_ff + Q_TWO_PI;
      end
      clamped = wrapped;
      if (wrapped > Q_QUARTER_PI) begin
         clamped = Q_QUARTER_PI;
      end else if (wrapped < -Q_QUARTER_PI) begin
         clamped = -Q_QUARTER_PI;
      end
      speed_cmd = {1'b0, speed};
      if (!meta_ff[POS_ADD].forward) begin
         speed_cmd = -speed_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         angle_ff     <= clamped[13:0];
         speed_cmd_ff <= speed_cmd;
      end
   end

   assign rsp_tvalid = vld_ff[POS_OUT];
   assign rsp_tdata  = {1'b0, speed_cmd_ff, angle_ff};

endmodule

`default_nettype wire

FILE: test/tb_stanley_steering_law_core.sv
// ----------------------------------------------------------------------------
// tb_stanley_steering_law_core
// Self-checking bench for the Stanley steering law core.
//
// Poses go in on the req_ stream, and steering angle and speed come out on
// rsp_. A behavioral copy of the steering law predicts every result, and
// results are compared in order. Both sides stall at random. One long
// receiver hold-off fills the internal queue so that the input stalls.
// Gain and speed are rewritten between phases while the core is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_stanley_steering_law_core;
   import ssl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 24;
   localparam int MAX_CYCLES  = 400000;
   localparam int DRAIN_WAIT  = 60;

   // Expected result of one pose.
   typedef struct {
      logic signed [13:0] steer_angle;
      logic signed [16:0] speed_command;
   } steer_cmd_type;

   // One row of the directed table. A row with known set also carries its result.
   typedef struct {
      logic signed [23:0] rel_x;
      logic signed [23:0] rel_y;
      logic signed [15:0] rel_heading;
      logic               forward;
      logic               known;
      logic signed [13:0] steer_angle;
   } pose_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;   // rel_x, rel_y, rel_heading
   logic        req_tuser = 1'b0; // forward
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // steer_angle, speed_command, zero pad
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_GAIN;
   logic [15:0] csr_data = '0;

   // Configuration shadow of the core's registers.
   logic [15:0] gain_q8 = 16'd1280;
   logic [15:0] speed_mm = 16'd1000;

   steer_cmd_type pending_cmds[$];
   pose_row_type  pose_table[TABLE_DEPTH];
   int            mismatch_count = 0;
   int            result_count = 0;
   int            cycle_count = 0;
   bit            hold_rsp = 1'b0;
   bit            hold_active = 1'b0;
   bit            hold_done = 1'b0;

   stanley_steering_law_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clock with a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // This counts cycles and ends the run if it hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > MAX_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Floor square root, one bit per step.
   function automatic longint unsigned floor_root(longint unsigned n);
      longint unsigned root;
      longint unsigned bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // Vectoring CORDIC angle of (den, num), rounded to Q2.13.
   function automatic longint cordic_angle(longint num, longint den);
      longint xv;
      longint yv;
      longint zv;
      longint xs;
      longint ys;
      xv = den;
      yv = num;
      zv = 0;
      for (int i = 0; i < CORDIC_USED; i++) begin
         xs = xv >>> i;
         ys = yv >>> i;
         if (yv > 0) begin
            xv = xv + ys;
            yv = yv - xs;
            zv += longint'(ATAN_TABLE[i]);
         end else begin
            xv = xv - ys;
            yv = yv + xs;
            zv -= longint'(ATAN_TABLE[i]);
         end
      end
      return (zv + 1024) >>> 11;
   endfunction

   // Steering law: heading plus the signed atan of the gained error, wrapped and clamped.
   function automatic steer_cmd_type steer_law(logic signed [23:0] px, logic signed [23:0] py,
                                               logic signed [15:0] head, logic fwd);
      steer_cmd_type   cmd;
      longint          xl;
      longint          yl;
      longint unsigned dist_mm;
      longint          term;
      longint          angle;
      xl = px;
      yl = py;
      dist_mm = floor_root(longint'(xl * xl + yl * yl));
      term = 0;
      if (dist_mm != 0) begin
         term = cordic_angle(longint'(gain_q8) * longint'(dist_mm),
                             (longint'(speed_mm) + 1) * 256);
         if (!(yl > 0)) term = -term;
      end
      angle = (fwd ? longint'(head) : -longint'(head)) + term;
      while (angle > Q_PI) angle -= Q_TWO_PI;
      while (angle < -Q_PI) angle += Q_TWO_PI;
      if (angle > Q_QUARTER_PI) angle = Q_QUARTER_PI;
      if (angle < -Q_QUARTER_PI) angle = -Q_QUARTER_PI;
      cmd.steer_angle = angle[13:0];
      cmd.speed_command = fwd ? 17'(speed_mm) : -17'(speed_mm);
      return cmd;
   endfunction

   // One register write on the configuration channel.
   task automatic write_reg(logic idx, logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == CSR_GAIN) gain_q8 = val;
      else speed_mm = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one pose, after a random gap when gaps is set, and record what it should produce.
   // Entered at a falling edge; valid stays high so that items can follow
   // back to back, and is dropped only for a gap or by wait_idle.
   task automatic send_pose(logic signed [23:0] px, logic signed [23:0] py,
                            logic signed [15:0] head, logic fwd, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 18) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {8'h00, head, py, px};
      req_tuser <= fwd;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_cmds.push_back(steer_law(px, py, head, fwd));
      @(negedge clock);
   endtask

   // Pose from the directed table, with a fixed result check on known rows.
   task automatic send_row(pose_row_type row);
      steer_cmd_type cmd;
      cmd = steer_law(row.rel_x, row.rel_y, row.rel_heading, row.forward);
      if (row.known && cmd.steer_angle !== row.steer_angle) begin
         mismatch_count++;
         $display("Table row angle %0d, predicted %0d", row.steer_angle, cmd.steer_angle);
      end
      send_pose(row.rel_x, row.rel_y, row.rel_heading, row.forward, 1'b1);
   endtask

   // Wait until every expected result has come, then let the pipeline settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_cmds.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // Random pose: mostly moderate offsets, sometimes full range.
   task automatic random_pose();
      logic signed [23:0] px;
      logic signed [23:0] py;
      logic signed [15:0] head;
      case ($urandom_range(0, 3))
         0: begin
            px = 24'($urandom);
            py = 24'($urandom);
         end
         1: begin
            px = 24'($signed($urandom_range(0, 4000)) - 2000);
            py = 24'($signed($urandom_range(0, 4000)) - 2000);
         end
         default: begin
            px = 24'($signed($urandom_range(0, 200)) - 100);
            py = 24'($signed($urandom_range(0, 200)) - 100);
         end
      endcase
      if ($urandom_range(0, 3) == 0) head = 16'($urandom);
      else head = 16'($signed($urandom_range(0, 51472)) - 25736);
      send_pose(px, py, head, 1'($urandom), 1'b1);
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp && !hold_done) begin
            rsp_tready <= 1'b0;
            hold_active = 1'b1;
            repeat (300) @(negedge clock);
            hold_active = 1'b0;
            hold_done = 1'b1;
         end
         stall = (cycle_count % 4000 < 1500) ? 0 : $urandom_range(0, 18);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   // This compares each accepted result with the oldest prediction.
   always @(posedge clock) begin
      steer_cmd_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         result_count++;
         if (pending_cmds.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result %h", rsp_tdata);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_tdata[13:0] !== want.steer_angle ||
                rsp_tdata[30:14] !== want.speed_command || rsp_tdata[31] !== 1'b0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: angle %0d exp %0d, speed %0d exp %0d",
                           $signed(rsp_tdata[13:0]), want.steer_angle,
                           $signed(rsp_tdata[30:14]), want.speed_command);
            end
         end
      end
   end

   // Stimulus: directed table, a long receiver hold-off, then random phases under several settings.
   initial begin
      pose_table = '{
         '{24'sd0, 24'sd0, 16'sd0, 1'b1, 1'b1, 14'sd0},
         '{24'sd0, 24'sd0, 16'sd25736, 1'b1, 1'b1, 14'sd6434},
         '{24'sd0, 24'sd0, -16'sd25736, 1'b1, 1'b1, -14'sd6434},
         '{24'sd0, 24'sd0, 16'sd1000, 1'b0, 1'b1, -14'sd1000},
         '{24'sd0, 24'sd0, 16'sd32767, 1'b1, 1'b1, -14'sd6434},
         '{24'sd0, 24'sd0, -16'sd32768, 1'b1, 1'b1, 14'sd6434},
         '{24'sd0, 24'sd0, -16'sd32768, 1'b0, 1'b1, -14'sd6434},
         '{24'sd0, 24'sd0, 16'sd6434, 1'b1, 1'b1, 14'sd6434},
         '{24'sd0, 24'sd0, 16'sd6435, 1'b1, 1'b1, 14'sd6434},
         '{24'sd8388607, 24'sd8388607, 16'sd0, 1'b1, 1'b1, 14'sd6434},
         '{-24'sd8388608, -24'sd8388608, 16'sd0, 1'b1, 1'b1, -14'sd6434},
         '{24'sd8388607, -24'sd8388608, 16'sd0, 1'b0, 1'b1, -14'sd6434},
         '{-24'sd8388608, 24'sd8388607, -16'sd32768, 1'b0, 1'b0, 14'sd0},
         '{24'sd1, 24'sd0, 16'sd0, 1'b1, 1'b0, 14'sd0},
         '{24'sd0, 24'sd1, 16'sd0, 1'b1, 1'b0, 14'sd0},
         '{24'sd0, -24'sd1, 16'sd0, 1'b0, 1'b0, 14'sd0},
         '{24'sd200, 24'sd0, 16'sd0, 1'b1, 1'b0, 14'sd0},
         '{24'sd0, 24'sd200, -16'sd500, 1'b1, 1'b0, 14'sd0},
         '{-24'sd150, -24'sd150, 16'sd300, 1'b0, 1'b0, 14'sd0},
         '{24'sd5000, 24'sd1, 16'sd25000, 1'b1, 1'b0, 14'sd0},
         '{24'sd30, -24'sd40, -16'sd25000, 1'b1, 1'b0, 14'sd0},
         '{24'sd1000, 24'sd1000, 16'sd0, 1'b1, 1'b0, 14'sd0},
         '{-24'sd3, 24'sd4, 16'sd12000, 1'b0, 1'b0, 14'sd0},
         '{24'sd12, 24'sd0, -16'sd12000, 1'b0, 1'b0, 14'sd0}
      };
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed poses with the reset defaults.
      foreach (pose_table[i]) send_row(pose_table[i]);
      wait_idle();

      // Long receiver hold-off while poses keep coming, enough to fill the
      // whole pipeline and the queue behind it.
      hold_rsp = 1'b1;
      while (!hold_active) @(negedge clock);
      for (int i = 0; i < 80; i++) send_pose(24'sd120, 24'(i * 37 - 200), 16'sd0, 1'b1, 1'b0);
      wait_idle();

      // Random phases under different gain and speed settings, extremes included.
      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin write_reg(CSR_GAIN, 16'd0); write_reg(CSR_SPEED, 16'd0); end
            1: begin write_reg(CSR_GAIN, 16'hFFFF); write_reg(CSR_SPEED, 16'hFFFF); end
            2: begin write_reg(CSR_GAIN, 16'hFFFF); write_reg(CSR_SPEED, 16'd0); end
            3: begin write_reg(CSR_GAIN, 16'd256); write_reg(CSR_SPEED, 16'd2000); end
            default: begin
               write_reg(CSR_GAIN, 16'($urandom));
               write_reg(CSR_SPEED, 16'($urandom));
            end
         endcase
         for (int i = 0; i < 58; i++) random_pose();
         wait_idle();
      end

      $display("Covered %0d results over directed poses, a queue-filling stall", result_count);
      $display("and six gain/speed settings, zero and full scale among them.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: stanley_steering_law_core.f
rtl/ssl_pkg.sv
rtl/ssl_front.sv
rtl/ssl_back.sv
rtl/stanley_steering_law_core.sv
test/tb_stanley_steering_law_core.sv
